// ===== sv/scp_pkg.sv =====
`default_nettype none

package scp_pkg;

    // register and field widths that do not vary
    localparam int FT_BITS     = 16;
    localparam int RADIUS_BITS = 20;

    // frame time register
    localparam logic [FT_BITS-1:0] FT_RESET      = 16'd1092;
    localparam logic [FT_BITS-1:0] DT_ZERO_SUBST = 16'd66;

    // fixed scalings of the datapath
    localparam int PRED_SHIFT   = 16;
    localparam int SQRT_SHIFT   = 12;
    localparam int RADIUS_SHIFT = 7;
    localparam int PUSH_SHIFT   = 7;
    localparam int CONV_SHIFT   = 8;

    typedef enum logic {
        MODE_SPHERE = 1'b0,
        MODE_BOX    = 1'b1
    } t_mode;

    typedef struct packed {
        logic self_phys;
        logic other_phys;
        logic rigid;
    } t_flags;

endpackage

`default_nettype wire

// ===== sv/sphere_collision_push_unit.sv =====
`default_nettype none

// channel   direction  handshake                fields
// cfg       in         i_cfg_valid/o_cfg_ready  i_cfg_data (frame time)
// in        in         i_in_valid/o_in_stall    i_mode .. i_other_is_rigid
// out       out        o_out_valid/i_out_stall  o_self_change .. o_other_changed
//
// one item enters per cycle while o_in_stall is low; the pipeline holds the
// square root (one bit per stage), the push divider (one quotient bit per
// stage) and the frame time divider.
// reset clears all valid bits and loads the frame time with 1092.
// a stalled output item freezes the whole pipeline; nothing is lost or repeated.

module sphere_collision_push_unit #(
    parameter int COMPONENT_BITS = 21
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [scp_pkg::FT_BITS-1:0]   i_cfg_data,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic                          i_mode,
    input  wire logic [3*COMPONENT_BITS-1:0]   i_self_centre,
    input  wire logic [3*COMPONENT_BITS-1:0]   i_self_velocity,
    input  wire logic [3*COMPONENT_BITS-1:0]   i_other_centre,
    input  wire logic [3*COMPONENT_BITS-1:0]   i_other_velocity,
    input  wire logic [3*COMPONENT_BITS-1:0]   i_box_extent,
    input  wire logic [scp_pkg::RADIUS_BITS-1:0] i_sphere_radius,
    input  wire logic                          i_self_has_physics,
    input  wire logic                          i_other_has_physics,
    input  wire logic                          i_other_is_rigid,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic      [3*COMPONENT_BITS-1:0]   o_self_change,
    output logic                               o_self_change_is_velocity,
    output logic      [3*COMPONENT_BITS-1:0]   o_other_change,
    output logic                               o_other_change_is_velocity,
    output logic                               o_other_changed
);

    localparam int C    = COMPONENT_BITS;
    localparam int VW   = 3 * C;
    localparam int FTW  = scp_pkg::FT_BITS;
    localparam int RDW  = scp_pkg::RADIUS_BITS;
    localparam int PRW  = C + FTW + 1;
    localparam int PW   = C + 3;
    localparam int DW   = C + 4;
    localparam int SQW  = 2 * DW;
    localparam int XW   = SQW + scp_pkg::SQRT_SHIFT;
    localparam int RW   = DW + 6;
    localparam int RRW  = RDW + scp_pkg::RADIUS_SHIFT;
    localparam int EW   = ((RW > RRW) ? RW : RRW) + 1;
    localparam int FW   = DW + EW;
    localparam int MW   = FW + scp_pkg::PUSH_SHIFT;
    localparam int DVW  = RW + 1;
    localparam int QW   = EW + 1;
    localparam int TRW  = QW + 1 - scp_pkg::CONV_SHIFT;
    localparam int VNW  = QW + scp_pkg::CONV_SHIFT + 1;
    localparam int LS   = RW + 1;
    localparam int LD   = QW + 1;
    localparam int LV   = C + 1;
    localparam logic [QW-1:0] SAT_MAX = QW'((64'd1 << (C - 1)) - 64'd1);
    localparam logic [QW-1:0] SAT_MIN = QW'(64'd1 << (C - 1));

    // frame time register
    logic [FTW-1:0] r_frame_time;
    logic [FTW-1:0] n_dt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_time <= scp_pkg::FT_RESET;
        end else if (i_cfg_valid) begin
            r_frame_time <= i_cfg_data;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign n_dt = (r_frame_time == '0) ? scp_pkg::DT_ZERO_SUBST : r_frame_time;

    // global advance: the pipeline moves unless the output item is held
    logic en;
    logic r_out_valid;

    assign en         = !r_out_valid || !i_out_stall;
    assign o_in_stall = !en;

    // stage a: velocity times frame time
    logic                 r_a_valid;
    scp_pkg::t_mode       r_a_mode;
    scp_pkg::t_flags      r_a_flags;
    logic [RDW-1:0]       r_a_rad;
    logic signed [C-1:0]  r_a_c  [3];
    logic signed [C-1:0]  r_a_oc [3];
    logic signed [C-1:0]  r_a_e  [3];
    logic signed [PRW-1:0] r_a_sp [3];
    logic signed [PRW-1:0] r_a_op [3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_mode  <= scp_pkg::t_mode'(i_mode);
            r_a_flags <= '{self_phys: i_self_has_physics, other_phys: i_other_has_physics,
                           rigid: i_other_is_rigid};
            r_a_rad   <= i_sphere_radius;
            for (int i = 0; i < 3; i++) begin
                r_a_c[i]  <= $signed(i_self_centre[i*C +: C]);
                r_a_oc[i] <= $signed(i_other_centre[i*C +: C]);
                r_a_e[i]  <= $signed(i_box_extent[i*C +: C]);
                r_a_sp[i] <= $signed(i_self_velocity[i*C +: C]) * $signed({1'b0, r_frame_time});
                r_a_op[i] <= $signed(i_other_velocity[i*C +: C]) * $signed({1'b0, r_frame_time});
            end
        end
    end

    // stage b: rounded prediction, doubled centres
    logic                 r_b_valid;
    scp_pkg::t_mode       r_b_mode;
    scp_pkg::t_flags      r_b_flags;
    logic [RDW-1:0]       r_b_rad;
    logic signed [C-1:0]  r_b_e    [3];
    logic signed [PW-1:0] r_b_pos  [3];
    logic signed [PW-1:0] r_b_opos [3];
    logic signed [PW-1:0] n_b_pos  [3];
    logic signed [PW-1:0] n_b_opos [3];
    logic [PRW-1:0]       n_b_sm   [3];
    logic [PRW-1:0]       n_b_om   [3];
    logic [PRW:0]         n_b_ss   [3];
    logic [PRW:0]         n_b_os   [3];
    logic signed [PW-1:0] n_b_sr   [3];
    logic signed [PW-1:0] n_b_or   [3];
    logic signed [PW-1:0] n_b_spv  [3];
    logic signed [PW-1:0] n_b_opv  [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_b_sm[i]  = r_a_sp[i][PRW-1] ? PRW'(-r_a_sp[i]) : PRW'(r_a_sp[i]);
            n_b_om[i]  = r_a_op[i][PRW-1] ? PRW'(-r_a_op[i]) : PRW'(r_a_op[i]);
            n_b_ss[i]  = {1'b0, n_b_sm[i]} + ((PRW+1)'(1) << (scp_pkg::PRED_SHIFT - 1));
            n_b_os[i]  = {1'b0, n_b_om[i]} + ((PRW+1)'(1) << (scp_pkg::PRED_SHIFT - 1));
            n_b_sr[i]  = PW'(n_b_ss[i][PRW:scp_pkg::PRED_SHIFT]);
            n_b_or[i]  = PW'(n_b_os[i][PRW:scp_pkg::PRED_SHIFT]);
            n_b_spv[i] = r_a_sp[i][PRW-1] ? -n_b_sr[i] : n_b_sr[i];
            n_b_opv[i] = r_a_op[i][PRW-1] ? -n_b_or[i] : n_b_or[i];
            if (!r_a_flags.self_phys) begin
                n_b_spv[i] = '0;
            end
            if (!r_a_flags.other_phys) begin
                n_b_opv[i] = '0;
            end
            n_b_pos[i]  = (PW'(r_a_c[i]) + n_b_spv[i]) <<< 1;
            n_b_opos[i] = (PW'(r_a_oc[i]) + n_b_opv[i]) <<< 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_mode  <= r_a_mode;
            r_b_flags <= r_a_flags;
            r_b_rad   <= r_a_rad;
            for (int i = 0; i < 3; i++) begin
                r_b_e[i]    <= r_a_e[i];
                r_b_pos[i]  <= n_b_pos[i];
                r_b_opos[i] <= n_b_opos[i];
            end
        end
    end

    // stage c: closest point and offset
    logic                 r_c_valid;
    scp_pkg::t_flags      r_c_flags;
    logic [RDW-1:0]       r_c_rad;
    logic signed [DW-1:0] r_c_d  [3];
    logic signed [DW-1:0] n_c_lo [3];
    logic signed [DW-1:0] n_c_hi [3];
    logic signed [DW-1:0] n_c_p  [3];
    logic signed [DW-1:0] n_c_cl [3];
    logic signed [DW-1:0] n_c_d  [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_c_p[i]  = DW'(r_b_pos[i]);
            n_c_lo[i] = DW'(r_b_opos[i]) - DW'(r_b_e[i]);
            n_c_hi[i] = DW'(r_b_opos[i]) + DW'(r_b_e[i]);
            if (n_c_p[i] < n_c_lo[i]) begin
                n_c_cl[i] = n_c_lo[i];
            end else if (n_c_p[i] > n_c_hi[i]) begin
                n_c_cl[i] = n_c_hi[i];
            end else begin
                n_c_cl[i] = n_c_p[i];
            end
            if (r_b_mode == scp_pkg::MODE_BOX) begin
                n_c_d[i] = n_c_p[i] - n_c_cl[i];
            end else begin
                n_c_d[i] = n_c_p[i] - DW'(r_b_opos[i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_flags <= r_b_flags;
            r_c_rad   <= r_b_rad;
            for (int i = 0; i < 3; i++) begin
                r_c_d[i] <= n_c_d[i];
            end
        end
    end

    // stage d: squares
    logic                 r_d_valid;
    scp_pkg::t_flags      r_d_flags;
    logic [RDW-1:0]       r_d_rad;
    logic signed [DW-1:0] r_d_d  [3];
    logic [SQW-1:0]       r_d_sq [3];
    logic [SQW-1:0]       n_d_sum;
    logic [XW-1:0]        n_d_x;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d_flags <= r_c_flags;
            r_d_rad   <= r_c_rad;
            for (int i = 0; i < 3; i++) begin
                r_d_d[i]  <= r_c_d[i];
                r_d_sq[i] <= SQW'(r_c_d[i] * r_c_d[i]);
            end
        end
    end

    assign n_d_sum = r_d_sq[0] + r_d_sq[1] + r_d_sq[2];
    assign n_d_x   = {n_d_sum, {scp_pkg::SQRT_SHIFT{1'b0}}};

    // distance
    logic [RW-1:0] s_root;

    scp_sqrt_pipe #(
        .XW (XW),
        .RW (RW)
    ) u_sqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_x    (n_d_x),
        .o_root (s_root)
    );

    // side data alongside the square root
    logic                 r_s_valid [LS];
    scp_pkg::t_flags      r_s_flags [LS];
    logic [RDW-1:0]       r_s_rad   [LS];
    logic signed [DW-1:0] r_s_d     [LS][3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s_flags[0] <= r_d_flags;
            r_s_rad[0]   <= r_d_rad;
            r_s_d[0]     <= r_d_d;
            for (int k = 1; k < LS; k++) begin
                r_s_flags[k] <= r_s_flags[k-1];
                r_s_rad[k]   <= r_s_rad[k-1];
                r_s_d[k]     <= r_s_d[k-1];
            end
        end
    end

    // stage f: offset times (radius - distance)
    logic                 r_f_valid;
    scp_pkg::t_flags      r_f_flags;
    logic [RDW-1:0]       r_f_rad;
    logic [RW-1:0]        r_f_dist;
    logic                 r_f_zero;
    logic signed [FW-1:0] r_f_prod [3];
    logic [RRW-1:0]       n_f_rr;
    logic signed [EW-1:0] n_f_diff;

    assign n_f_rr   = RRW'(r_s_rad[LS-1]) << scp_pkg::RADIUS_SHIFT;
    assign n_f_diff = $signed(EW'(n_f_rr)) - $signed(EW'(s_root));

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f_flags <= r_s_flags[LS-1];
            r_f_rad   <= r_s_rad[LS-1];
            r_f_dist  <= s_root;
            r_f_zero  <= (s_root == '0);
            for (int i = 0; i < 3; i++) begin
                r_f_prod[i] <= r_s_d[LS-1][i] * n_f_diff;
            end
        end
    end

    // push magnitudes: rounded |n| / (distance, doubled when rigid)
    logic signed [MW-1:0] n_g_n   [3];
    logic [MW-1:0]        n_g_abs [3];
    logic [MW-1:0]        n_g_num [3];
    logic [DVW-1:0]       n_g_dv;
    logic [QW-1:0]        g_q     [3];
    logic                 g_ovf   [3];

    assign n_g_dv = r_f_flags.rigid ? {r_f_dist, 1'b0} : {1'b0, r_f_dist};

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_g_n[i]   = MW'(r_f_prod[i]) <<< scp_pkg::PUSH_SHIFT;
            n_g_abs[i] = n_g_n[i][MW-1] ? MW'(-n_g_n[i]) : MW'(n_g_n[i]);
            n_g_num[i] = n_g_abs[i] + MW'(n_g_dv >> 1);
        end
    end

    for (genvar i = 0; i < 3; i++) begin : g_push_div
        scp_div_pipe #(
            .NW (MW),
            .VW (DVW),
            .QW (QW)
        ) u_div (
            .i_clk (i_clk),
            .i_en  (en),
            .i_num (n_g_num[i]),
            .i_div (n_g_dv),
            .o_quo (g_q[i]),
            .o_ovf (g_ovf[i])
        );
    end

    // side data alongside the push divider
    logic            r_g_valid [LD];
    scp_pkg::t_flags r_g_flags [LD];
    logic [RDW-1:0]  r_g_rad   [LD];
    logic            r_g_zero  [LD];
    logic [2:0]      r_g_neg   [LD];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_g_flags[0] <= r_f_flags;
            r_g_rad[0]   <= r_f_rad;
            r_g_zero[0]  <= r_f_zero;
            r_g_neg[0]   <= {r_f_prod[2][FW-1], r_f_prod[1][FW-1], r_f_prod[0][FW-1]};
            for (int k = 1; k < LD; k++) begin
                r_g_flags[k] <= r_g_flags[k-1];
                r_g_rad[k]   <= r_g_rad[k-1];
                r_g_zero[k]  <= r_g_zero[k-1];
                r_g_neg[k]   <= r_g_neg[k-1];
            end
        end
    end

    // push selection, translation rounding, velocity numerator
    logic [QW-1:0]  n_h_rad;
    logic [QW-1:0]  n_h_zv;
    logic [QW-1:0]  n_h_pm  [3];
    logic [2:0]     n_h_neg;
    logic [QW:0]    n_h_ts  [3];
    logic [TRW-1:0] n_h_tr  [3];
    logic [VNW-1:0] n_h_vn  [3];
    logic [C-1:0]   v_q     [3];
    logic           v_ovf   [3];

    assign n_h_rad = QW'(r_g_rad[LD-1]) << scp_pkg::CONV_SHIFT;
    assign n_h_zv  = r_g_flags[LD-1].rigid ? ((n_h_rad + QW'(1)) >> 1) : n_h_rad;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (r_g_zero[LD-1]) begin
                // zero distance: direction (1,0,1) scaled by the radius
                n_h_pm[i]  = (i == 1) ? '0 : n_h_zv;
                n_h_neg[i] = 1'b0;
            end else begin
                n_h_pm[i]  = g_ovf[i] ? '1 : g_q[i];
                n_h_neg[i] = r_g_neg[LD-1][i];
            end
            n_h_ts[i] = {1'b0, n_h_pm[i]} + ((QW+1)'(1) << (scp_pkg::CONV_SHIFT - 1));
            n_h_tr[i] = n_h_ts[i][QW:scp_pkg::CONV_SHIFT];
            n_h_vn[i] = (VNW'(n_h_pm[i]) << scp_pkg::CONV_SHIFT) + VNW'(n_dt >> 1);
        end
    end

    for (genvar i = 0; i < 3; i++) begin : g_vel_div
        scp_div_pipe #(
            .NW (VNW),
            .VW (FTW),
            .QW (C)
        ) u_div (
            .i_clk (i_clk),
            .i_en  (en),
            .i_num (n_h_vn[i]),
            .i_div (n_dt),
            .o_quo (v_q[i]),
            .o_ovf (v_ovf[i])
        );
    end

    // side data alongside the velocity divider
    logic            r_v_valid [LV];
    scp_pkg::t_flags r_v_flags [LV];
    logic [2:0]      r_v_neg   [LV];
    logic [TRW-1:0]  r_v_tr    [LV][3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_v_flags[0] <= r_g_flags[LD-1];
            r_v_neg[0]   <= n_h_neg;
            r_v_tr[0]    <= n_h_tr;
            for (int k = 1; k < LV; k++) begin
                r_v_flags[k] <= r_v_flags[k-1];
                r_v_neg[k]   <= r_v_neg[k-1];
                r_v_tr[k]    <= r_v_tr[k-1];
            end
        end
    end

    // signed saturation of a magnitude
    function automatic logic [C-1:0] f_sat(input logic neg, input logic [QW-1:0] mag);
        logic [C-1:0] v;
        if (!neg && mag > SAT_MAX) begin
            v = {1'b0, {(C-1){1'b1}}};
        end else if (neg && mag > SAT_MIN) begin
            v = {1'b1, {(C-1){1'b0}}};
        end else if (neg) begin
            v = C'(-mag);
        end else begin
            v = C'(mag);
        end
        return v;
    endfunction

    // output stage
    logic [QW-1:0] n_o_vm [3];
    logic [QW-1:0] n_o_tm [3];
    logic [VW-1:0] n_o_self;
    logic [VW-1:0] n_o_other;
    scp_pkg::t_flags o_fl;

    assign o_fl = r_v_flags[LV-1];

    always_comb begin
        n_o_self  = '0;
        n_o_other = '0;
        for (int i = 0; i < 3; i++) begin
            n_o_vm[i] = v_ovf[i] ? '1 : QW'(v_q[i]);
            n_o_tm[i] = QW'(r_v_tr[LV-1][i]);
            n_o_self[i*C +: C] = f_sat(r_v_neg[LV-1][i],
                                       o_fl.self_phys ? n_o_vm[i] : n_o_tm[i]);
            if (o_fl.rigid) begin
                n_o_other[i*C +: C] = f_sat(!r_v_neg[LV-1][i],
                                            o_fl.other_phys ? n_o_vm[i] : n_o_tm[i]);
            end
        end
    end

    logic [VW-1:0] r_out_self;
    logic [VW-1:0] r_out_other;
    logic          r_out_self_vel;
    logic          r_out_other_vel;
    logic          r_out_other_chg;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_self      <= n_o_self;
            r_out_other     <= n_o_other;
            r_out_self_vel  <= o_fl.self_phys;
            r_out_other_vel <= o_fl.rigid && o_fl.other_phys;
            r_out_other_chg <= o_fl.rigid;
        end
    end

    // valid bits travel with the items
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_b_valid   <= 1'b0;
            r_c_valid   <= 1'b0;
            r_d_valid   <= 1'b0;
            r_f_valid   <= 1'b0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < LS; k++) begin
                r_s_valid[k] <= 1'b0;
            end
            for (int k = 0; k < LD; k++) begin
                r_g_valid[k] <= 1'b0;
            end
            for (int k = 0; k < LV; k++) begin
                r_v_valid[k] <= 1'b0;
            end
        end else if (en) begin
            r_a_valid    <= i_in_valid;
            r_b_valid    <= r_a_valid;
            r_c_valid    <= r_b_valid;
            r_d_valid    <= r_c_valid;
            r_s_valid[0] <= r_d_valid;
            for (int k = 1; k < LS; k++) begin
                r_s_valid[k] <= r_s_valid[k-1];
            end
            r_f_valid    <= r_s_valid[LS-1];
            r_g_valid[0] <= r_f_valid;
            for (int k = 1; k < LD; k++) begin
                r_g_valid[k] <= r_g_valid[k-1];
            end
            r_v_valid[0] <= r_g_valid[LD-1];
            for (int k = 1; k < LV; k++) begin
                r_v_valid[k] <= r_v_valid[k-1];
            end
            r_out_valid  <= r_v_valid[LV-1];
        end
    end

    assign o_out_valid                = r_out_valid;
    assign o_self_change              = r_out_self;
    assign o_self_change_is_velocity  = r_out_self_vel;
    assign o_other_change             = r_out_other;
    assign o_other_change_is_velocity = r_out_other_vel;
    assign o_other_changed            = r_out_other_chg;

endmodule

`default_nettype wire

// ===== sv/scp_sqrt_pipe.sv =====
`default_nettype none

module scp_sqrt_pipe #(
    parameter int XW = 62,
    parameter int RW = 31
) (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  wire logic [XW-1:0] i_x,
    output logic      [RW-1:0] o_root
);

    localparam int TW = XW + 2;

    logic [XW-1:0] r_rem  [RW+1];
    logic [RW-1:0] r_root [RW+1];
    logic [XW-1:0] n_rem  [RW];
    logic [RW-1:0] n_root [RW];
    logic [TW-1:0] n_t    [RW];

    // one root bit per stage, most significant first
    always_comb begin
        for (int k = 0; k < RW; k++) begin
            n_t[k] = (TW'(r_root[k]) << (RW - k)) + (TW'(1) << (2 * (RW - 1 - k)));
            if (TW'(r_rem[k]) >= n_t[k]) begin
                n_rem[k]  = XW'(TW'(r_rem[k]) - n_t[k]);
                n_root[k] = r_root[k] | (RW'(1) << (RW - 1 - k));
            end else begin
                n_rem[k]  = r_rem[k];
                n_root[k] = r_root[k];
            end
        end
    end

    // stage registers
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= i_x;
            r_root[0] <= '0;
            for (int k = 0; k < RW; k++) begin
                r_rem[k+1]  <= n_rem[k];
                r_root[k+1] <= n_root[k];
            end
        end
    end

    assign o_root = r_root[RW];

endmodule

`default_nettype wire

// ===== sv/scp_div_pipe.sv =====
`default_nettype none

module scp_div_pipe #(
    parameter int NW = 64,
    parameter int VW = 33,
    parameter int QW = 33
) (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [VW-1:0] i_div,
    output logic      [QW-1:0] o_quo,
    output logic               o_ovf
);

    localparam int TW = NW + VW;

    logic [NW-1:0] r_rem [QW+1];
    logic [VW-1:0] r_dv  [QW+1];
    logic [QW-1:0] r_q   [QW+1];
    logic          r_ovf [QW+1];
    logic [NW-1:0] n_rem [QW];
    logic [QW-1:0] n_q   [QW];
    logic [TW-1:0] n_t   [QW];
    logic          n_ovf;

    // quotient that would not fit in QW bits
    assign n_ovf = TW'(i_num >> QW) >= TW'(i_div);

    // restoring division, one quotient bit per stage
    always_comb begin
        for (int k = 0; k < QW; k++) begin
            n_t[k] = TW'(r_dv[k]) << (QW - 1 - k);
            if (TW'(r_rem[k]) >= n_t[k]) begin
                n_rem[k] = NW'(TW'(r_rem[k]) - n_t[k]);
                n_q[k]   = r_q[k] | (QW'(1) << (QW - 1 - k));
            end else begin
                n_rem[k] = r_rem[k];
                n_q[k]   = r_q[k];
            end
        end
    end

    // stage registers
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= i_num;
            r_dv[0]  <= i_div;
            r_q[0]   <= '0;
            r_ovf[0] <= n_ovf;
            for (int k = 0; k < QW; k++) begin
                r_rem[k+1] <= n_rem[k];
                r_dv[k+1]  <= r_dv[k];
                r_q[k+1]   <= n_q[k];
                r_ovf[k+1] <= r_ovf[k];
            end
        end
    end

    assign o_quo = r_q[QW];
    assign o_ovf = r_ovf[QW];

endmodule

`default_nettype wire

// ===== sv/scp_checker.sv =====
`default_nettype none

module scp_checker #(
    parameter int COMPONENT_BITS = 21
) (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        i_out_stall,
    input wire logic                        o_in_stall,
    input wire logic                        o_out_valid,
    input wire logic [3*COMPONENT_BITS-1:0] o_self_change,
    input wire logic [3*COMPONENT_BITS-1:0] o_other_change,
    input wire logic                        o_other_change_is_velocity,
    input wire logic                        o_other_changed
);

    // a held output item stays
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output item dropped while stalled");

    // a held output item keeps its vectors
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_self_change) && $stable(o_other_change))
        else $error("output item changed while stalled");

    // the other body is untouched unless it is rigid
    a_other_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_other_changed |-> o_other_change == '0 && !o_other_change_is_velocity)
        else $error("other body changed without rigid flag");

    // input stalls only behind a held output item
    a_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled with free output");

endmodule

bind sphere_collision_push_unit scp_checker #(
    .COMPONENT_BITS (COMPONENT_BITS)
) u_scp_checker (.*);

`default_nettype wire

// ===== bench/sphere_collision_push_unit_test.sv =====
`default_nettype none

module sphere_collision_push_unit_test;

    localparam int CB  = 21;
    localparam int VW  = 3*CB;
    localparam int RB  = scp_pkg::RADIUS_BITS;
    localparam int FTB = scp_pkg::FT_BITS;
    localparam int LATENCY = 3*CB + 31;
    localparam longint CYCLE_LIMIT = 2_000_000;

    typedef struct {
        logic [VW-1:0] self_change;
        logic          self_is_vel;
        logic [VW-1:0] other_change;
        logic          other_is_vel;
        logic          other_changed;
    } t_push;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_valid;
    logic cfg_ready;
    logic [FTB-1:0] cfg_data;
    logic in_valid;
    logic in_stall;
    logic mode;
    logic [VW-1:0] self_centre, self_velocity, other_centre, other_velocity, box_extent;
    logic [RB-1:0] sphere_radius;
    logic self_phys, other_phys, rigid;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [VW-1:0] o_self, o_other;
    logic o_self_vel, o_other_vel, o_other_changed;

    // model copy of the frame time register
    logic [FTB-1:0] frame_time_q;
    t_push pending_pushes[$];
    int  mismatches = 0;
    int  results_seen = 0;
    int  items_sent = 0;
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    longint cycles = 0;

    always #2 clk = ~clk;

    sphere_collision_push_unit #(.COMPONENT_BITS(CB)) i_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_mode(mode), .i_self_centre(self_centre), .i_self_velocity(self_velocity),
        .i_other_centre(other_centre), .i_other_velocity(other_velocity),
        .i_box_extent(box_extent), .i_sphere_radius(sphere_radius),
        .i_self_has_physics(self_phys), .i_other_has_physics(other_phys),
        .i_other_is_rigid(rigid),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_self_change(o_self), .o_self_change_is_velocity(o_self_vel),
        .o_other_change(o_other), .o_other_change_is_velocity(o_other_vel),
        .o_other_changed(o_other_changed)
    );

    // rounded division, ties away from zero
    function automatic longint round_div(longint n, longint d);
        if (n >= 0) return (n + d/2) / d;
        return -((-n + d/2) / d);
    endfunction

    function automatic longint component(logic [VW-1:0] v, int i);
        logic signed [CB-1:0] c;
        c = v[i*CB +: CB];
        return longint'(c);
    endfunction

    function automatic logic [CB-1:0] saturate(longint v);
        longint hi, lo;
        hi = (longint'(1) << (CB-1)) - 1;
        lo = -hi - 1;
        if (v > hi) v = hi;
        if (v < lo) v = lo;
        return v[CB-1:0];
    endfunction

    function automatic longint int_sqrt(longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return longint'(r);
    endfunction

    function automatic longint to_change(longint p, logic vel, longint dt);
        if (vel) return round_div(p * 256, dt);
        return round_div(p, 256);
    endfunction

    // expected push for the item currently on the input ports
    function automatic t_push predict_push();
        t_push r;
        longint ft, dt, pos, opos, e, lo, hi, c, distance, rr;
        longint d[3], p[3];
        longint unsigned sum;
        ft = longint'(frame_time_q);
        dt = (ft != 0) ? ft : longint'(scp_pkg::DT_ZERO_SUBST);
        sum = 0;
        for (int i = 0; i < 3; i++) begin
            pos  = component(self_centre, i);
            opos = component(other_centre, i);
            if (self_phys)  pos  += round_div(component(self_velocity, i) * ft, 65536);
            if (other_phys) opos += round_div(component(other_velocity, i) * ft, 65536);
            pos *= 2;
            opos *= 2;
            if (scp_pkg::t_mode'(mode) == scp_pkg::MODE_BOX) begin
                e = component(box_extent, i);
                lo = opos - e;
                hi = opos + e;
                c = pos;
                if (c < lo) c = lo;
                else if (c > hi) c = hi;
                d[i] = pos - c;
            end else begin
                d[i] = pos - opos;
            end
            sum += longint'(d[i] * d[i]);
        end
        if (sum > 0) begin
            distance = int_sqrt(sum << 12);
            rr = longint'(sphere_radius) << 7;
            for (int i = 0; i < 3; i++)
                p[i] = round_div(d[i] * (rr - distance) * 128, distance << rigid);
        end else begin
            // coincident points push along (1,0,1)
            p[0] = round_div(longint'(sphere_radius) << 8, longint'(1) << rigid);
            p[1] = 0;
            p[2] = p[0];
        end
        r.self_change = '0;
        r.other_change = '0;
        for (int i = 0; i < 3; i++) begin
            r.self_change[i*CB +: CB] = saturate(to_change(p[i], self_phys, dt));
            if (rigid) r.other_change[i*CB +: CB] = saturate(to_change(-p[i], other_phys, dt));
        end
        r.self_is_vel = self_phys;
        r.other_is_vel = rigid & other_phys;
        r.other_changed = rigid;
        return r;
    endfunction

    // receiver stall, capture of expected pushes and result checking
    always @(posedge clk) begin
        t_push exp_r;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t timeout", $time);
            $display("end of test: mismatches");
            $finish;
        end
        if (rst_n && in_valid && !in_stall) begin
            pending_pushes.push_back(predict_push());
        end
        if (rst_n && out_valid && !out_stall) begin
            results_seen++;
            if (pending_pushes.size() == 0) begin
                mismatches++;
                $display("%0t unexpected item: self %h other %h", $time, o_self, o_other);
            end else begin
                exp_r = pending_pushes.pop_front();
                if (o_self !== exp_r.self_change || o_self_vel !== exp_r.self_is_vel ||
                    o_other !== exp_r.other_change || o_other_vel !== exp_r.other_is_vel ||
                    o_other_changed !== exp_r.other_changed) begin
                    mismatches++;
                    $display("%0t expected %h/%b %h/%b/%b actual %h/%b %h/%b/%b", $time,
                             exp_r.self_change, exp_r.self_is_vel, exp_r.other_change,
                             exp_r.other_is_vel, exp_r.other_changed, o_self, o_self_vel,
                             o_other, o_other_vel, o_other_changed);
                end
            end
        end
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    function automatic logic [CB-1:0] rand_comp(int unsigned span);
        longint v;
        v = longint'($urandom_range(2*span)) - longint'(span);
        return v[CB-1:0];
    endfunction

    function automatic logic [VW-1:0] pack3(logic [CB-1:0] x, logic [CB-1:0] y,
                                            logic [CB-1:0] z);
        return {z, y, x};
    endfunction

    // one item: optional idle gap, then hold until accepted
    task automatic send_item(logic m, logic [VW-1:0] sc, logic [VW-1:0] sv,
                             logic [VW-1:0] oc, logic [VW-1:0] ov, logic [VW-1:0] be,
                             logic [RB-1:0] rad, logic sp, logic op, logic rg);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        mode <= m; self_centre <= sc; self_velocity <= sv; other_centre <= oc;
        other_velocity <= ov; box_extent <= be; sphere_radius <= rad;
        self_phys <= sp; other_phys <= op; rigid <= rg;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        items_sent++;
    endtask

    task automatic release_input();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        while (pending_pushes.size() != 0) @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    task automatic write_frame_time(logic [FTB-1:0] v);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        frame_time_q = v;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // a random pair with random content
    task automatic send_random_pair();
        int unsigned span;
        logic [VW-1:0] sc, oc;
        span = ($urandom_range(9) == 0) ? (1 << (CB-1)) : $urandom_range(4000, 1);
        sc = pack3(rand_comp(span), rand_comp(span), rand_comp(span));
        oc = ($urandom_range(15) == 0) ? sc :
             pack3(rand_comp(span), rand_comp(span), rand_comp(span));
        send_item(1'($urandom_range(1)), sc, VW'({$urandom, $urandom}),
                  oc, VW'({$urandom, $urandom}),
                  ($urandom_range(7) == 0) ? VW'({$urandom, $urandom}) :
                      pack3(rand_comp(span), rand_comp(span), rand_comp(span)),
                  ($urandom_range(7) == 0) ? RB'($urandom) :
                      RB'($urandom_range(8000)),
                  1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)));
    endtask

    task automatic test_directed_extremes();
        logic [VW-1:0] ones, zero, maxv, minv;
        ones = '1; zero = '0;
        maxv = pack3({1'b0, {(CB-1){1'b1}}}, {1'b0, {(CB-1){1'b1}}}, {1'b0, {(CB-1){1'b1}}});
        minv = pack3({1'b1, {(CB-1){1'b0}}}, {1'b1, {(CB-1){1'b0}}}, {1'b1, {(CB-1){1'b0}}});
        for (int f = 0; f < 8; f++) begin
            // coincident centres and opposite extreme centres, both modes
            send_item(f[0], zero, zero, zero, zero, zero, '1, f[1], f[2], f[0] ^ f[2]);
            send_item(~f[0], maxv, maxv, minv, minv, maxv, '1, f[0], f[1], f[2]);
        end
        // negative box extent, far apart, all ones, separated
        send_item(scp_pkg::MODE_BOX, pack3(21'd500, 21'd0, 21'd0), zero, zero, zero, minv,
                  20'd100, 1'b0, 1'b0, 1'b1);
        send_item(scp_pkg::MODE_BOX, pack3(21'd500, 21'd0, 21'd0), zero, zero, zero,
                  pack3(-21'sd8, 21'd4, -21'sd2), 20'd100, 1'b1, 1'b1, 1'b1);
        send_item(scp_pkg::MODE_SPHERE, ones, ones, ones, ones, ones, '0, 1'b1, 1'b1, 1'b1);
        send_item(scp_pkg::MODE_SPHERE, pack3(21'd256, 21'd0, 21'd0), zero, zero, zero, zero,
                  20'd512, 1'b0, 1'b0, 1'b0);
        send_item(scp_pkg::MODE_BOX, maxv, ones, minv, maxv, zero, '0, 1'b1, 1'b1, 1'b0);
        send_item(scp_pkg::MODE_SPHERE, minv, maxv, maxv, minv, ones, 20'd1, 1'b1, 1'b0, 1'b1);
        release_input();
    endtask

    task automatic test_random_phase(int n, int idle, int stall);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        for (int k = 0; k < n; k++) send_random_pair();
        release_input();
        wait_drained();
    endtask

    task automatic test_frame_times();
        write_frame_time(16'd0);
        test_random_phase(60, 0, 0);
        write_frame_time(16'hFFFF);
        test_random_phase(60, 18, 18);
        write_frame_time(16'd1);
        test_random_phase(40, 0, 0);
        write_frame_time(16'($urandom));
        test_random_phase(40, 0, 79);
        write_frame_time(scp_pkg::FT_RESET);
    endtask

    initial begin
        rst_n = 1'b0;
        cfg_valid = 1'b0; cfg_data = '0; in_valid = 1'b0;
        mode = 1'b0; self_centre = '0; self_velocity = '0; other_centre = '0;
        other_velocity = '0; box_extent = '0; sphere_radius = '0;
        self_phys = 1'b0; other_phys = 1'b0; rigid = 1'b0;
        frame_time_q = scp_pkg::FT_RESET;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_extremes();
        wait_drained();
        test_random_phase(300, 0, 0);
        test_random_phase(250, 79, 0);
        test_random_phase(250, 0, 79);
        test_random_phase(200, 18, 18);
        test_frame_times();
        test_directed_extremes();
        wait_drained();

        $display("covered %0d items, %0d results, both modes, six frame time settings",
                 items_sent, results_seen);
        $display("idle and stall phases on both channels, zero distance and crossed boxes");
        if (mismatches == 0 && pending_pushes.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== sphere_collision_push_unit.f =====
sv/scp_pkg.sv
sv/scp_sqrt_pipe.sv
sv/scp_div_pipe.sv
sv/sphere_collision_push_unit.sv
sv/scp_checker.sv
bench/sphere_collision_push_unit_test.sv
